>>> hdl/pvsd_pkg.sv
// Shared types, constants and the length decode for the prefix varint stream decoder.
package pvsd_pkg;

   // Code length limits and field widths.
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned VALUE_W      = 64;
   localparam int unsigned LEN_W        = 4;
   localparam logic [3:0]  LONG_CODE_LEN = 4'd9;
   localparam logic [3:0]  SHORT_CODE_LEN = 4'd1;

   // One input beat.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              buffer_end;
   } pvsd_beat_type;

   // One result beat.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [LEN_W-1:0]   byte_length;
      logic               truncated;
   } pvsd_result_type;

   // Decoder state as seen by the top level for checking.
   typedef struct packed {
      logic             busy;
      logic [LEN_W-1:0] bytes_seen;
      logic [LEN_W-1:0] code_length;
   } pvsd_status_type;

   // Code length from the first byte: trailing zeros plus one, nine for a zero byte.
   function automatic logic [LEN_W-1:0] code_length_of(input logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] n;
      n = LONG_CODE_LEN;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         if (b[i]) begin
            n = LEN_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

>>> hdl/pvsd_in_stage.sv
// Input register of the prefix varint stream decoder.
module pvsd_in_stage
   import pvsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  pvsd_beat_type req_beat,
   input  logic          advance,
   output logic          beat_valid,
   output pvsd_beat_type beat
);

   logic          valid_ff;
   logic          valid_in;
   pvsd_beat_type beat_ff;

   // The register takes a new beat when empty or when its beat moves on.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is loaded only with an accepted beat.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         beat_ff <= req_beat;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

>>> hdl/pvsd_decode.sv
// Per-byte decode step and code state of the prefix varint stream decoder.
module pvsd_decode
   import pvsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  pvsd_beat_type   beat,
   output logic            res_valid,
   output pvsd_result_type result,
   output pvsd_status_type status
);

   logic [LEN_W-1:0]   bytes_seen_ff,  bytes_seen_in;
   logic [LEN_W-1:0]   code_length_ff, code_length_in;
   logic [VALUE_W-1:0] acc_ff,         acc_in;

   logic               first;
   logic [LEN_W-1:0]   first_len;
   logic [BYTE_W-1:0]  first_bits;
   logic [6:0]         shift_full;
   logic [5:0]         shift;
   logic [VALUE_W-1:0] acc_merged;
   logic [LEN_W-1:0]   seen;

   assign first      = (bytes_seen_ff == '0);
   assign first_len  = code_length_of(beat.data_byte);
   assign first_bits = BYTE_W'(beat.data_byte >> first_len);

   // Bit position of a later byte; the long code places whole bytes above a zero tag.
   always_comb begin
      if (code_length_ff == LONG_CODE_LEN) begin
         shift_full = {bytes_seen_ff - 4'd1, 3'b000};
      end else begin
         shift_full = {bytes_seen_ff, 3'b000} - {3'b000, code_length_ff};
      end
   end
   assign shift      = shift_full[5:0];
   assign acc_merged = acc_ff | ({{(VALUE_W-BYTE_W){1'b0}}, beat.data_byte} << shift);
   assign seen       = bytes_seen_ff + 4'd1;

   // Next state and result for one accepted beat.
   always_comb begin
      bytes_seen_in  = bytes_seen_ff;
      code_length_in = code_length_ff;
      acc_in         = acc_ff;
      res_valid      = 1'b0;
      result         = '0;
      if (first) begin
         if (first_len == SHORT_CODE_LEN) begin
            res_valid          = 1'b1;
            result.value       = {{(VALUE_W-BYTE_W){1'b0}}, first_bits};
            result.byte_length = SHORT_CODE_LEN;
         end else if (beat.buffer_end) begin
            res_valid          = 1'b1;
            result.byte_length = SHORT_CODE_LEN;
            result.truncated   = 1'b1;
         end else begin
            bytes_seen_in  = 4'd1;
            code_length_in = first_len;
            acc_in         = (first_len == LONG_CODE_LEN) ? '0
                           : {{(VALUE_W-BYTE_W){1'b0}}, first_bits};
         end
      end else begin
         if (seen >= code_length_ff) begin
            res_valid          = 1'b1;
            result.value       = acc_merged;
            result.byte_length = code_length_ff;
            bytes_seen_in      = '0;
            code_length_in     = '0;
            acc_in             = '0;
         end else if (beat.buffer_end) begin
            res_valid          = 1'b1;
            result.byte_length = seen;
            result.truncated   = 1'b1;
            bytes_seen_in      = '0;
            code_length_in     = '0;
            acc_in             = '0;
         end else begin
            bytes_seen_in = seen;
            acc_in        = acc_merged;
         end
      end
   end

   // Code state advances only when a beat is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff  <= '0;
         code_length_ff <= '0;
         acc_ff         <= '0;
      end else if (fire) begin
         bytes_seen_ff  <= bytes_seen_in;
         code_length_ff <= code_length_in;
         acc_ff         <= acc_in;
      end
   end

   assign status.busy        = !first;
   assign status.bytes_seen  = bytes_seen_ff;
   assign status.code_length = code_length_ff;

endmodule

>>> hdl/pvsd_out_stage.sv
// Result register of the prefix varint stream decoder.
module pvsd_out_stage
   import pvsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic            res_valid,
   input  pvsd_result_type result,
   output logic            advance,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output pvsd_result_type rsp_result
);

   logic            valid_ff;
   logic            valid_in;
   pvsd_result_type result_ff;

   // The stage before may move whenever this register is empty or being drained.
   assign advance  = !valid_ff || rsp_ready;
   assign valid_in = advance ? (fire && res_valid) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

>>> hdl/prefix_varint_stream_decoder.sv
// Top level of the prefix varint stream decoder.
//
//   channel  direction  ports                                      beat
//   req      in         req_valid/ready, req_data_byte, req_buffer_end   one stream byte
//   rsp      out        rsp_valid/ready, rsp_value, rsp_byte_length, rsp_truncated
//                                                                  one decoded code
//
// One byte is taken every clock cycle unless the result side stalls; a last byte goes
// through the input register, the rate-setting decode step and the result register.
// Synchronous reset empties both registers and returns the decoder to wait for a first byte.
// A stalled result holds the result register; the input register then fills and req_ready
// drops, and bytes that produce no result still pass while the result register is free.
module prefix_varint_stream_decoder
   import pvsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_buffer_end,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic [LEN_W-1:0]    rsp_byte_length,
   output logic                rsp_truncated
);

   pvsd_beat_type   req_beat;
   pvsd_beat_type   beat;
   logic            beat_valid;
   logic            advance;
   logic            fire;
   logic            res_valid;
   pvsd_result_type result;
   pvsd_result_type rsp_result;
   pvsd_status_type status;

   assign req_beat.data_byte  = req_data_byte;
   assign req_beat.buffer_end = req_buffer_end;
   assign fire                = beat_valid && advance;

   pvsd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_beat   (req_beat),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   pvsd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .beat      (beat),
      .res_valid (res_valid),
      .result    (result),
      .status    (status)
   );

   pvsd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .res_valid  (res_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_value       = rsp_result.value;
   assign rsp_byte_length = rsp_result.byte_length;
   assign rsp_truncated   = rsp_result.truncated;

   // A code in progress always has a multi-byte length and is not yet complete.
   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> (status.code_length >= 4'd2) && (status.code_length <= LONG_CODE_LEN)
                      && (status.bytes_seen < status.code_length))
      else $error("decoder state out of range");

   // A truncated result carries a zero value and a partial length.
   a_trunc_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_truncated) |-> (rsp_value == '0) && (rsp_byte_length != 4'd0)
                                        && (rsp_byte_length < LONG_CODE_LEN))
      else $error("bad truncated result");

   // A full input register behind a stalled result must hold off new bytes.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && beat_valid) |-> !req_ready)
      else $error("input accepted while both registers are held");

   // A consumed byte that finishes a code shows up as a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (fire && res_valid) |=> rsp_valid)
      else $error("finished code did not reach the result register");

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the prefix varint stream decoder.
module testbench
   import pvsd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any beat before the run is abandoned, and settle time at the end.
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BYTES = 1750;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_data_byte;
   logic                req_buffer_end;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [VALUE_W-1:0]  rsp_value;
   logic [LEN_W-1:0]    rsp_byte_length;
   logic                rsp_truncated;

   // Decoder state as tracked by the testbench.
   logic [LEN_W-1:0]    seen_count;
   logic [LEN_W-1:0]    code_len;
   logic [VALUE_W-1:0]  acc_bits;

   pvsd_result_type     expected_codes[$];
   pvsd_result_type     oldest_code;
   int                  mismatch_count = 0;
   int                  idle_cycles = 0;
   bit                  no_gaps = 1'b0;

   prefix_varint_stream_decoder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_buffer_end  (req_buffer_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_byte_length (rsp_byte_length),
      .rsp_truncated   (rsp_truncated)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly no gap, sometimes a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 20);
   endfunction

   // Random byte with the all-zeros and all-ones patterns favoured.
   function automatic logic [BYTE_W-1:0] random_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 8'h00;
      end else if (r == 1) begin
         return 8'hFF;
      end
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // Code length: one more than the count of low zero bits; a zero byte opens a long code.
   function automatic logic [LEN_W-1:0] length_of_first(input logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] n;
      bit               found;
      if (b == '0) begin
         return LONG_CODE_LEN;
      end
      n = SHORT_CODE_LEN;
      found = 1'b0;
      for (int k = 0; k < BYTE_W; k++) begin
         if (!found && !b[k]) begin
            n = n + 1'b1;
         end else begin
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic void queue_result(input logic [VALUE_W-1:0] v,
                                        input logic [LEN_W-1:0] len,
                                        input logic trunc);
      pvsd_result_type r;
      r.value       = v;
      r.byte_length = len;
      r.truncated   = trunc;
      expected_codes.push_back(r);
   endfunction

   function automatic void clear_decode();
      seen_count = '0;
      code_len   = '0;
      acc_bits   = '0;
   endfunction

   // Advance the tracked decoder by one accepted byte and queue any result it completes.
   function automatic void advance_decoder(input logic [BYTE_W-1:0] b, input logic last);
      logic [LEN_W-1:0] n;
      int               sh;
      int               nxt;
      if (seen_count == 0 || code_len == 0 || code_len > LONG_CODE_LEN) begin
         n = length_of_first(b);
         if (n == SHORT_CODE_LEN) begin
            clear_decode();
            queue_result(VALUE_W'(b >> 1), SHORT_CODE_LEN, 1'b0);
            return;
         end
         code_len   = n;
         seen_count = LEN_W'(1);
         acc_bits   = (n >= LONG_CODE_LEN) ? '0 : VALUE_W'(b >> n);
         if (last) begin
            clear_decode();
            queue_result('0, LEN_W'(1), 1'b1);
         end
         return;
      end
      // Long codes carry whole bytes; shorter ones sit above the first byte's spare bits.
      if (code_len == LONG_CODE_LEN) begin
         sh = 8 * (int'(seen_count) - 1);
      end else begin
         sh = 8 * int'(seen_count) - int'(code_len);
      end
      acc_bits = acc_bits | (VALUE_W'(b) << (sh & 63));
      nxt = int'(seen_count) + 1;
      if (nxt >= int'(code_len)) begin
         queue_result(acc_bits, code_len, 1'b0);
         clear_decode();
      end else if (last) begin
         clear_decode();
         queue_result('0, LEN_W'(nxt), 1'b1);
      end else begin
         seen_count = LEN_W'(nxt);
      end
   endfunction

   // Predict on accepted input beats, check result beats, and watch for a hang.
   always @(posedge clock) begin
      if (reset) begin
         clear_decode();
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            advance_decoder(req_data_byte, req_buffer_end);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               $error("result beat with no code pending: value %h", rsp_value);
               mismatch_count++;
            end else begin
               oldest_code = expected_codes.pop_front();
               if (rsp_value !== oldest_code.value) begin
                  $error("value: expected %h, got %h", oldest_code.value, rsp_value);
                  mismatch_count++;
               end
               if (rsp_byte_length !== oldest_code.byte_length) begin
                  $error("byte_length: expected %0d, got %0d",
                         oldest_code.byte_length, rsp_byte_length);
                  mismatch_count++;
               end
               if (rsp_truncated !== oldest_code.truncated) begin
                  $error("truncated: expected %0d, got %0d",
                         oldest_code.truncated, rsp_truncated);
                  mismatch_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Result side back-pressure: runs of ready broken by stalls of random length.
   initial begin
      int stall;
      rsp_ready = 1'b1;
      forever begin
         repeat ($urandom_range(1, 12)) @(negedge clock);
         stall = no_gaps ? 0 : pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one byte after an optional gap and hold it until the beat is taken.
   task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_buffer_end <= last;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   task automatic test_single_byte_codes();
      send_beat(8'h01, 1'b0);
      // The end marker has no effect on a code that is complete in one byte.
      send_beat(8'hFF, 1'b1);
   endtask

   task automatic test_nine_byte_code();
      send_beat(8'h00, 1'b0);
      repeat (7) send_beat(8'hFF, 1'b0);
      // The buffer ends exactly on the completing byte, which is not a truncation.
      send_beat(8'hFF, 1'b1);
   endtask

   task automatic test_two_byte_code();
      send_beat(8'hFE, 1'b0);
      send_beat(8'hFF, 1'b0);
   endtask

   task automatic test_eight_byte_code();
      send_beat(8'h80, 1'b0);
      repeat (7) send_beat(random_byte(), 1'b0);
   endtask

   task automatic test_truncation();
      // Buffer ends on the opening byte of a longer code.
      send_beat(8'h80, 1'b1);
      // Buffer ends part way through a long code.
      send_beat(8'h00, 1'b0);
      send_beat(8'h12, 1'b0);
      send_beat(8'h34, 1'b1);
   endtask

   // Mostly well-formed codes with random content, some cut short, some stray bytes.
   task automatic test_random_stream(input int n_bytes);
      int               sent;
      int               len;
      int               cut;
      logic [BYTE_W-1:0] b;
      logic              last;
      sent = 0;
      while (sent < n_bytes) begin
         no_gaps = ((sent / 250) % 3 == 2);
         if ($urandom_range(0, 9) == 0) begin
            send_beat(random_byte(), $urandom_range(0, 3) == 0);
            sent++;
         end else begin
            len = $urandom_range(1, 9);
            cut = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(0, len - 2) : -1;
            for (int k = 0; k < len; k++) begin
               if (k == 0) begin
                  b = (len == 9) ? 8'h00 : ((random_byte() << len) | (8'h01 << (len - 1)));
               end else begin
                  b = random_byte();
               end
               last = (k == cut) || (k == len - 1 && $urandom_range(0, 3) == 0);
               send_beat(b, last);
               sent++;
               if (k == cut) begin
                  break;
               end
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_buffer_end = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_byte_codes();
      test_nine_byte_code();
      test_two_byte_code();
      test_eight_byte_code();
      test_truncation();
      test_random_stream(RANDOM_BYTES);

      @(negedge clock);
      req_valid <= 1'b0;
      // Let every outstanding result drain, then give stray beats time to show.
      while (expected_codes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_codes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
